>>> design/pgs_pkg.sv
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared types and constants of the Gauss-Seidel Poisson solver core.
// ----------------------------------------------------------------------------
`default_nettype none

package pgs_pkg;

  // default geometry and fixed-point format
  localparam int DEF_MAX_ROWS  = 64;
  localparam int DEF_MAX_COLS  = 64;
  localparam int DEF_FRAC_BITS = 32;

  // value and operand widths
  localparam int VAL_W  = 48;   // Q15.32 signed cell value
  localparam int WGT_W  = 33;   // unsigned Q1.32 weight / squared size
  localparam int TOL_W  = 47;
  localparam int CNT_W  = 16;
  localparam int POS_W  = 7;
  localparam int OPA_W  = 51;   // multiplier magnitude operand
  localparam int MAG_W  = 62;   // scaled term magnitude
  localparam int ACC_W  = 64;   // full-width accumulator

  // input item kinds
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_SOLVE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_WRITTEN = 2'd0;
  localparam logic [1:0] ST_READ    = 2'd1;
  localparam logic [1:0] ST_CONV    = 2'd2;
  localparam logic [1:0] ST_LIMIT   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_ROWS  = 3'd0;
  localparam logic [2:0] CFG_COLS  = 3'd1;
  localparam logic [2:0] CFG_TOL   = 3'd2;
  localparam logic [2:0] CFG_WX    = 3'd3;
  localparam logic [2:0] CFG_WY    = 3'd4;
  localparam logic [2:0] CFG_WRHS  = 3'd5;
  localparam logic [2:0] CFG_MAXCK = 3'd6;

  // cap of one scaled second difference
  localparam logic [MAG_W-1:0] TERM_CAP = MAG_W'(1) << 61;

  // grid write enables
  typedef struct packed {
    logic p_we;
    logic r_we;
  } grid_we_t;

  // multiplier status
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

`default_nettype wire

>>> design/pgs_mul.sv
// ----------------------------------------------------------------------------
// pgs_mul
// Shift-add multiplier, one multiplier bit per cycle, stops when the
// remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pgs_mul #(
  parameter int AW = 51,
  parameter int BW = 33
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [AW-1:0]        a,
  input  wire logic [BW-1:0]        b,
  output pgs_pkg::mul_stat_t        stat,
  output logic      [AW+BW-1:0]     prod
);
  import pgs_pkg::*;

  localparam int PW = AW + BW;

  logic [PW-1:0] a_sh;
  logic [BW-1:0] b_sh;
  logic          busy;
  logic          done;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && b_sh == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath: one conditional add per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= PW'(a);
      b_sh <= b;
      prod <= '0;
    end else if (busy && b_sh != '0) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

>>> design/pgs_grid.sv
// ----------------------------------------------------------------------------
// pgs_grid
// Potential grid (with ghost border) and rhs grid, one write and one
// registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module pgs_grid #(
  parameter int PD  = 4356,
  parameter int RD  = 4096,
  parameter int PAW = 13,
  parameter int RAW = 12
) (
  input  wire logic                         clk,
  input  wire pgs_pkg::grid_we_t            we,
  input  wire logic [PAW-1:0]               p_waddr,
  input  wire logic [pgs_pkg::VAL_W-1:0]    p_wdata,
  input  wire logic [PAW-1:0]               p_raddr,
  output logic      [pgs_pkg::VAL_W-1:0]    p_rdata,
  input  wire logic [RAW-1:0]               r_waddr,
  input  wire logic [pgs_pkg::VAL_W-1:0]    r_wdata,
  input  wire logic [RAW-1:0]               r_raddr,
  output logic      [pgs_pkg::VAL_W-1:0]    r_rdata
);
  import pgs_pkg::*;

  logic [VAL_W-1:0] pmem [PD];
  logic [VAL_W-1:0] rmem [RD];

  // potential grid
  always_ff @(posedge clk) begin
    if (we.p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    p_rdata <= pmem[p_raddr];
  end

  // rhs grid
  always_ff @(posedge clk) begin
    if (we.r_we) begin
      rmem[r_waddr] <= r_wdata;
    end
    r_rdata <= rmem[r_raddr];
  end

endmodule

`default_nettype wire

>>> design/poisson_gauss_seidel_solver_core.sv
// ----------------------------------------------------------------------------
// poisson_gauss_seidel_solver_core
// 2-D five-point Gauss-Seidel Poisson solver on a ghost-bordered grid.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command per transfer: tuser is the mode (write, solve,
//   read), tdata holds row, col, potential and rhs. m_* returns one result
//   per command: tuser is the status, tdata holds the read value, the check
//   count and the last maximum residual. cfg_* writes the size, tolerance,
//   weights and check limit; it is always ready and unguarded: use it while idle.
// Sequence:
//   A write goes from accept through the done state, a read through a
//   capture state and the done state, to a result in the output register.
//   A solve fetches per cell, over the one grid read port, the four
//   neighbours, the rhs, the cell itself (residual) or its row's last
//   cell (sweep) and its column's last cell; then the shift-add unit runs
//   3 (sweep) or 2 (residual) products; a sweep writes back cell and ghosts;
//   each pass steps over rows*cols cells, until convergence or the limit.
//   s_tready is high only while idle. The next command is taken while a
//   result still waits in the output register.
// Reset:
//   rst clears control state and loads the register defaults. Grid contents
//   are undefined until written. A stalled receiver holds the result and
//   holds the block in its final state until the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module poisson_gauss_seidel_solver_core #(
  parameter int MAX_ROWS  = pgs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = pgs_pkg::DEF_MAX_COLS,
  parameter int FRAC_BITS = pgs_pkg::DEF_FRAC_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [111:0] s_tdata,   // row[6:0], col[13:7], phi_value[61:14],
                                       // rhs_value[109:62], zero pad
  input  wire logic [1:0]   s_tuser,   // mode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [111:0] m_tdata,   // cell_value[47:0], check_count[63:48],
                                       // residual[111:64]
  output logic      [1:0]   m_tuser,   // status
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [46:0]  cfg_data
);
  import pgs_pkg::*;

  localparam int STRIDE = MAX_COLS + 2;
  localparam int PD     = (MAX_ROWS + 2) * STRIDE;
  localparam int RD     = MAX_ROWS * MAX_COLS;
  localparam int PAW    = $clog2(PD);
  localparam int RAW    = $clog2(RD);
  localparam int RIW    = $clog2(MAX_ROWS + 2);
  localparam int CIW    = $clog2(MAX_COLS + 2);
  localparam int PW     = OPA_W + WGT_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RDCAP = 10'b0000000010,
    S_FETCH = 10'b0000000100,
    S_MSTRT = 10'b0000001000,
    S_MWAIT = 10'b0000010000,
    S_MPOST = 10'b0000100000,
    S_MACC  = 10'b0001000000,
    S_WB    = 10'b0010000000,
    S_NEXT  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  // address helpers
  function automatic logic [PAW-1:0] paddr(input logic [RIW-1:0] r, input logic [CIW-1:0] c);
    paddr = PAW'(int'(r) * STRIDE + int'(c));
  endfunction

  function automatic logic [RAW-1:0] raddr(input logic [RIW-1:0] r, input logic [CIW-1:0] c);
    raddr = RAW'((int'(r) - 1) * MAX_COLS + (int'(c) - 1));
  endfunction

  function automatic logic signed [VAL_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] vmax;
    logic signed [ACC_W-1:0] vmin;
    vmax = ACC_W'({1'b0, {(VAL_W-1){1'b1}}});
    vmin = -vmax - ACC_W'(1);
    if (v > vmax) begin
      sat48 = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (v < vmin) begin
      sat48 = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat48 = v[VAL_W-1:0];
    end
  endfunction

  // configuration registers
  logic [6:0]       cfg_rows;
  logic [6:0]       cfg_cols;
  logic [TOL_W-1:0] cfg_tol;
  logic [WGT_W-1:0] cfg_wx;
  logic [WGT_W-1:0] cfg_wy;
  logic [WGT_W-1:0] cfg_wrhs;
  logic [CNT_W-1:0] cfg_maxck;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_rows  <= 7'd64;
      cfg_cols  <= 7'd64;
      cfg_tol   <= TOL_W'(429);
      cfg_wx    <= WGT_W'(33'd1073741824);
      cfg_wy    <= WGT_W'(33'd1073741824);
      cfg_wrhs  <= WGT_W'(33'd524288);
      cfg_maxck <= CNT_W'(1000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS:  cfg_rows  <= cfg_data[6:0];
        CFG_COLS:  cfg_cols  <= cfg_data[6:0];
        CFG_TOL:   cfg_tol   <= cfg_data;
        CFG_WX:    cfg_wx    <= cfg_data[WGT_W-1:0];
        CFG_WY:    cfg_wy    <= cfg_data[WGT_W-1:0];
        CFG_WRHS:  cfg_wrhs  <= cfg_data[WGT_W-1:0];
        CFG_MAXCK: cfg_maxck <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes and limit
  logic [RIW-1:0]   nr;
  logic [CIW-1:0]   nc;
  logic [CNT_W-1:0] limit_eff;

  always_comb begin
    if (cfg_rows == '0) begin
      nr = RIW'(1);
    end else if (int'(cfg_rows) > MAX_ROWS) begin
      nr = RIW'(MAX_ROWS);
    end else begin
      nr = RIW'(cfg_rows);
    end
    if (cfg_cols == '0) begin
      nc = CIW'(1);
    end else if (int'(cfg_cols) > MAX_COLS) begin
      nc = CIW'(MAX_COLS);
    end else begin
      nc = CIW'(cfg_cols);
    end
    limit_eff = (cfg_maxck == '0) ? CNT_W'(1) : cfg_maxck;
  end

  // input fields
  logic [1:0]       in_mode;
  logic [POS_W-1:0] in_row;
  logic [POS_W-1:0] in_col;
  logic [VAL_W-1:0] in_phi;
  logic [VAL_W-1:0] in_rhs;
  logic [RIW-1:0]   in_r;
  logic [CIW-1:0]   in_c;
  logic             in_range;
  logic             in_inner;
  logic             s_accept;

  assign in_mode  = s_tuser;
  assign in_row   = s_tdata[6:0];
  assign in_col   = s_tdata[13:7];
  assign in_phi   = s_tdata[61:14];
  assign in_rhs   = s_tdata[109:62];
  assign in_r     = RIW'(in_row);
  assign in_c     = CIW'(in_col);
  assign in_range = (int'(in_row) <= int'(nr) + 1) && (int'(in_col) <= int'(nc) + 1);
  assign in_inner = (in_row != '0) && (int'(in_row) <= int'(nr)) &&
                    (in_col != '0) && (int'(in_col) <= int'(nc));
  assign s_accept = s_tvalid && s_tready;

  // sequencer state
  state_t                  state;
  logic [1:0]              mode_q;
  logic [1:0]              status_q;
  logic [VAL_W-1:0]        cell_q;
  logic [VAL_W-1:0]        resid_q;
  logic                    rd_ok;
  logic [CNT_W-1:0]        checks;
  logic [3:0]              decade;      // sweep_count mod 10
  logic                    pass_res;    // residual pass vs sweep
  logic                    first;
  logic signed [ACC_W-1:0] best;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] term;
  logic [RIW-1:0]          ci;
  logic [CIW-1:0]          cj;
  logic [2:0]              step;
  logic [1:0]              mi;
  logic [WGT_W-1:0]        sr;
  logic [WGT_W-1:0]        sc;
  logic signed [VAL_W-1:0] nb [6];      // up, dn, lf, rt, center/right, bottom
  logic signed [VAL_W-1:0] rhs_q;
  logic                    neg_q;
  logic                    cap_q;

  // grid port
  grid_we_t         gwe;
  logic [PAW-1:0]   p_waddr;
  logic [VAL_W-1:0] p_wdata;
  logic [PAW-1:0]   p_raddr;
  logic [VAL_W-1:0] p_rdata;
  logic [RAW-1:0]   r_waddr;
  logic [VAL_W-1:0] r_wdata;
  logic [RAW-1:0]   r_raddr;
  logic [VAL_W-1:0] r_rdata;

  // multiplier port
  logic             mul_start;
  logic [OPA_W-1:0] mul_a;
  logic [WGT_W-1:0] mul_b;
  mul_stat_t        mul_stat;
  logic [PW-1:0]    mul_prod;

  logic signed [VAL_W-1:0] v_new;
  assign v_new = sat48(acc);

  // grid access selection
  always_comb begin
    gwe     = '0;
    p_waddr = paddr(in_r, in_c);
    p_wdata = in_phi;
    p_raddr = paddr(in_r, in_c);
    r_waddr = raddr(in_r, in_c);
    r_wdata = in_rhs;
    r_raddr = raddr(ci, cj);
    case (state)
      S_IDLE: begin
        if (s_accept && in_mode == MODE_WRITE) begin
          gwe.p_we = in_range;
          gwe.r_we = in_inner;
        end
      end
      S_FETCH: begin
        case (step)
          3'd0:    p_raddr = paddr(ci - RIW'(1), cj);
          3'd1:    p_raddr = paddr(ci + RIW'(1), cj);
          3'd2:    p_raddr = paddr(ci, cj - CIW'(1));
          3'd3:    p_raddr = paddr(ci, cj + CIW'(1));
          3'd4:    p_raddr = pass_res ? paddr(ci, cj) : paddr(ci, nc);
          default: p_raddr = paddr(nr, cj);
        endcase
      end
      S_WB: begin
        p_wdata = v_new;
        case (step)
          3'd0: begin
            p_waddr  = paddr(ci, cj);
            gwe.p_we = 1'b1;
          end
          3'd1: begin
            p_waddr  = paddr(ci, CIW'(0));
            gwe.p_we = (cj == CIW'(1));
          end
          3'd2: begin
            // right ghost: old edge value at row start, new at row end
            p_waddr  = paddr(ci, nc + CIW'(1));
            p_wdata  = (cj == nc) ? v_new : nb[4];
            gwe.p_we = (cj == nc) || (cj == CIW'(1));
          end
          3'd3: begin
            p_waddr  = paddr(RIW'(0), cj);
            gwe.p_we = (ci == RIW'(1));
          end
          default: begin
            // bottom ghost: old edge value on the first row, new on the last
            p_waddr  = paddr(nr + RIW'(1), cj);
            p_wdata  = (ci == nr) ? v_new : nb[5];
            gwe.p_we = (ci == nr) || (ci == RIW'(1));
          end
        endcase
      end
      default: ;
    endcase
  end

  // multiplier operand selection
  logic signed [OPA_W-1:0] x_sel;
  logic [WGT_W-1:0]        b_sel;
  logic                    sub_sel;

  always_comb begin
    x_sel   = OPA_W'(rhs_q);
    b_sel   = cfg_wrhs;
    sub_sel = 1'b1;
    if (pass_res) begin
      if (mi == 2'd0) begin
        x_sel = OPA_W'(nb[0]) + OPA_W'(nb[1]) - OPA_W'(nb[4]) - OPA_W'(nb[4]);
        b_sel = sr;
      end else begin
        x_sel = OPA_W'(nb[2]) + OPA_W'(nb[3]) - OPA_W'(nb[4]) - OPA_W'(nb[4]);
        b_sel = sc;
      end
    end else begin
      case (mi)
        2'd0: begin
          x_sel   = OPA_W'(nb[0]) + OPA_W'(nb[1]);
          b_sel   = cfg_wx;
          sub_sel = 1'b0;
        end
        2'd1: begin
          x_sel   = OPA_W'(nb[2]) + OPA_W'(nb[3]);
          b_sel   = cfg_wy;
          sub_sel = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign mul_start = (state == S_MSTRT);
  assign mul_a     = x_sel[OPA_W-1] ? OPA_W'(-x_sel) : OPA_W'(x_sel);
  assign mul_b     = b_sel;

  // product post-processing: rounded weight product or capped term
  logic [PW-1:0]    rnd;
  logic [MAG_W-1:0] mag;

  always_comb begin
    rnd = (mul_prod + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (cap_q) begin
      mag = (mul_prod > PW'(TERM_CAP)) ? TERM_CAP : mul_prod[MAG_W-1:0];
    end else begin
      mag = rnd[MAG_W-1:0];
    end
  end

  // end-of-cell decisions
  logic signed [ACC_W-1:0] best_nx;
  logic [CNT_W-1:0]        checks_inc;
  logic                    last_cell;
  logic                    below_tol;

  assign best_nx    = (first || acc > best) ? acc : best;
  assign checks_inc = checks + CNT_W'(1);
  assign last_cell  = (cj == nc) && (ci == nr);
  assign below_tol  = best_nx < signed'(ACC_W'(cfg_tol));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      checks   <= '0;
      decade   <= '0;
      pass_res <= 1'b0;
      first    <= 1'b0;
      step     <= '0;
      mi       <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            case (in_mode)
              MODE_SOLVE: begin
                checks   <= '0;
                decade   <= '0;
                pass_res <= 1'b0;
                step     <= '0;
                state    <= S_FETCH;
              end
              MODE_READ: state <= S_RDCAP;
              default:   state <= S_DONE;
            endcase
          end
        end
        S_RDCAP: state <= S_DONE;
        S_FETCH: begin
          if (step == 3'd6) begin
            mi    <= '0;
            state <= S_MSTRT;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_MSTRT: state <= S_MWAIT;
        S_MWAIT: begin
          if (mul_stat.done) begin
            state <= S_MPOST;
          end
        end
        S_MPOST: state <= S_MACC;
        S_MACC: begin
          if (pass_res ? (mi == 2'd1) : (mi == 2'd2)) begin
            step  <= '0;
            state <= pass_res ? S_NEXT : S_WB;
          end else begin
            mi    <= mi + 2'd1;
            state <= S_MSTRT;
          end
        end
        S_WB: begin
          if (step == 3'd4) begin
            state <= S_NEXT;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_NEXT: begin
          step  <= '0;
          state <= S_FETCH;
          if (pass_res) begin
            first <= 1'b0;
          end
          if (last_cell) begin
            if (!pass_res) begin
              if (decade == 4'd0) begin
                pass_res <= 1'b1;
                first    <= 1'b1;
              end else begin
                decade <= (decade == 4'd9) ? 4'd0 : decade + 4'd1;
              end
            end else begin
              checks <= checks_inc;
              if (below_tol || checks_inc >= limit_eff) begin
                state <= S_DONE;
              end else begin
                pass_res <= 1'b0;
                decade   <= 4'd1;
              end
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          mode_q   <= in_mode;
          rd_ok    <= in_range;
          cell_q   <= '0;
          resid_q  <= '0;
          ci       <= RIW'(1);
          cj       <= CIW'(1);
          sr       <= WGT_W'(nr) * WGT_W'(nr);
          sc       <= WGT_W'(nc) * WGT_W'(nc);
          case (in_mode)
            MODE_READ: status_q <= ST_READ;
            default:   status_q <= ST_WRITTEN;
          endcase
        end
      end
      S_RDCAP: begin
        cell_q <= rd_ok ? p_rdata : '0;
      end
      S_FETCH: begin
        if (step != 3'd0) begin
          nb[3'(step - 3'd1)] <= signed'(p_rdata);
        end
        if (step == 3'd1) begin
          rhs_q <= signed'(r_rdata);
        end
        if (step == 3'd6) begin
          acc <= pass_res ? ACC_W'(rhs_q) : '0;
        end
      end
      S_MSTRT: begin
        neg_q <= x_sel[OPA_W-1] ^ sub_sel;
        cap_q <= pass_res;
      end
      S_MPOST: begin
        term <= neg_q ? -signed'(ACC_W'(mag)) : signed'(ACC_W'(mag));
      end
      S_MACC: begin
        acc <= acc + term;
      end
      S_NEXT: begin
        if (pass_res) begin
          best <= best_nx;
        end
        if (!last_cell) begin
          if (cj == nc) begin
            cj <= CIW'(1);
            ci <= ci + RIW'(1);
          end else begin
            cj <= cj + CIW'(1);
          end
        end else begin
          ci <= RIW'(1);
          cj <= CIW'(1);
          if (pass_res) begin
            resid_q  <= sat48(best_nx);
            status_q <= below_tol ? ST_CONV : ST_LIMIT;
          end
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tuser <= status_q;
          m_tdata <= {resid_q, checks, cell_q};
        end
      end
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  pgs_grid #(
    .PD (PD),
    .RD (RD),
    .PAW(PAW),
    .RAW(RAW)
  ) u_grid (
    .clk    (clk),
    .we     (gwe),
    .p_waddr(p_waddr),
    .p_wdata(p_wdata),
    .p_raddr(p_raddr),
    .p_rdata(p_rdata),
    .r_waddr(r_waddr),
    .r_wdata(r_wdata),
    .r_raddr(r_raddr),
    .r_rdata(r_rdata)
  );

  pgs_mul #(
    .AW(OPA_W),
    .BW(WGT_W)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .stat (mul_stat),
    .prod (mul_prod)
  );

`ifndef SYNTHESIS
  // the shared multiplier is never restarted mid-product
  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  // grid writes only from a write command or the sweep write-back
  a_grid_we: assert property (@(posedge clk) disable iff (rst)
    gwe.p_we |-> (state == S_IDLE || state == S_WB))
    else $error("potential write outside write phases");

  // a finished solve reports converged or limit reached
  a_solve_st: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && mode_q == MODE_SOLVE) |-> (status_q == ST_CONV || status_q == ST_LIMIT))
    else $error("solve finished with wrong status");

  // while solving the check count stays below the limit
  a_checks: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (checks < limit_eff))
    else $error("check count reached limit without stopping");
`endif

endmodule

`default_nettype wire
